@@ src/hlfr_pkg.sv @@
// ----------------------------------------------------------------------------
// hlfr_pkg
// Shared types and constants for the header/length frame receiver: beat
// structs, status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package hlfr_pkg;

   localparam int FRAME_BYTES_DEFAULT = 64;
   localparam int RSP_QUEUE_DEPTH     = 4;

   localparam logic [7:0] HEADER_RESET = 8'hFF;
   localparam logic [7:0] CHECK_RESET  = 8'h00;

   // fixed frame layout
   localparam int DEST_POS = 2;
   localparam int SRC_POS  = 3;
   localparam int CMD_POS  = 4;
   localparam int LEN_POS  = 5;
   localparam int DATA_POS = 6;

   // register indexes (paddr bit 2)
   localparam logic REG_HEADER = 1'b0;
   localparam logic REG_CHECK  = 1'b1;

   // result status codes
   localparam logic [2:0] ST_WAIT    = 3'd0;
   localparam logic [2:0] ST_READY   = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_HDR1    = 3'd3;
   localparam logic [2:0] ST_HDR2    = 3'd4;
   localparam logic [2:0] ST_LEN     = 3'd5;
   localparam logic [2:0] ST_OVF     = 3'd6;
   localparam logic [2:0] ST_CHECK   = 3'd7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       timed_out;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] byte_position;
      logic [7:0] dest_addr;
      logic [7:0] src_addr;
      logic [7:0] command;
      logic [5:0] arg_count;
      logic       last;
   } rsp_type;

endpackage

@@ src/hlfr_result_queue.sv @@
// ----------------------------------------------------------------------------
// hlfr_result_queue
// Small result FIFO that takes up to two result beats per cycle and
// delivers one per cycle on the rsp channel while rsp_ready is high.
// ----------------------------------------------------------------------------
module hlfr_result_queue #(
   parameter int DEPTH = hlfr_pkg::RSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  hlfr_pkg::rsp_type push_first,
   input  hlfr_pkg::rsp_type push_second,
   input  logic [1:0]        push_cnt,
   output logic              room_for_two,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hlfr_pkg::rsp_type rsp_data
);
   import hlfr_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   rsp_type          entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop          = rsp_valid && rsp_ready;
   assign rsp_valid    = (count_ff != '0);
   assign rsp_data     = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CntW'(DEPTH - 2));

   always_comb begin
      wr_ptr_nx = ptr_inc(wr_ptr_ff);
      case (push_cnt)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_cnt) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_nx] <= push_second;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("result queue count above depth");

   a_push_has_room : assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> (count_ff <= CntW'(DEPTH - 2)))
      else $error("result pushed without room for two beats");

   a_double_push : assert property (@(posedge clock) disable iff (reset)
      (push_cnt == 2'd2 && !pop) |=> (count_ff == $past(count_ff) + CntW'(2)))
      else $error("double push did not add two entries");
`endif

endmodule

@@ src/header_length_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// header_length_frame_receiver
// Receives a byte stream and frames it as H H dest src cmd n args check.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while req_ready is high. Each byte is
// parsed in the cycle it is accepted against the frame position and length
// registers, and its one or two result beats go into a result queue of
// RSP_DEPTH entries (four by default); req_ready is high while that queue has
// room for two beats, so with rsp_ready held high the block sustains one byte
// per cycle. A timeout in mid-frame yields two beats (the timeout, then the
// byte's own outcome as the first byte of a new frame), so a run of such bytes
// is limited by the single rsp beat per cycle. Besides the length, only the
// destination, source and command bytes are kept, as nothing else is read out.
module header_length_frame_receiver #(
   parameter int FRAME_BYTES = hlfr_pkg::FRAME_BYTES_DEFAULT,
   parameter int RSP_DEPTH   = hlfr_pkg::RSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hlfr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hlfr_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import hlfr_pkg::*;

   localparam int PosW = $clog2(FRAME_BYTES + 1);
   localparam int CmpW = ((PosW > 8) ? PosW : 8) + 1;

   logic [7:0]      hdr_ff, chk_ff;
   logic [PosW-1:0] pos_ff, pos_in, pos0;
   logic [7:0]      len_ff, len_in;
   logic [7:0]      dest_ff, dest_in, src_ff, src_in, cmd_ff, cmd_in;
   logic [CmpW-1:0] pos_ext, pos0_ext;
   logic            take, restart, len_bad;
   logic [2:0]      take_st;
   logic            csr_write;
   rsp_type         res_timeout, res_take, push_first, push_second;
   logic [1:0]      push_cnt;

   assign take      = req_valid && req_ready;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // drop back to frame start on a mid-frame timeout before parsing the byte
   assign restart  = req_data.timed_out && (pos_ff != '0);
   assign pos0     = restart ? '0 : pos_ff;
   assign pos_ext  = CmpW'(pos_ff);
   assign pos0_ext = CmpW'(pos0);

   always_comb begin
      take_st = ST_WAIT;
      pos_in  = pos0 + 1'b1;
      len_in  = len_ff;
      len_bad = 1'b0;
      dest_in = dest_ff;
      src_in  = src_ff;
      cmd_in  = cmd_ff;
      if (pos0 >= PosW'(FRAME_BYTES)) begin
         take_st = ST_OVF;
         pos_in  = '0;
      end else begin
         if (pos0 == PosW'(DEST_POS)) dest_in = req_data.rx_byte;
         if (pos0 == PosW'(SRC_POS))  src_in  = req_data.rx_byte;
         if (pos0 == PosW'(CMD_POS))  cmd_in  = req_data.rx_byte;
         if (pos0 == '0) begin
            if (req_data.rx_byte != hdr_ff) begin
               take_st = ST_HDR1;
               pos_in  = '0;
            end
         end else if (pos0 == PosW'(1)) begin
            if (req_data.rx_byte != hdr_ff) begin
               take_st = ST_HDR2;
               pos_in  = '0;
            end
         end else begin
            if (pos0 == PosW'(LEN_POS)) begin
               if ({1'b0, req_data.rx_byte} >= 9'(FRAME_BYTES - LEN_POS)) begin
                  take_st = ST_LEN;
                  pos_in  = '0;
                  len_bad = 1'b1;
               end else begin
                  len_in = req_data.rx_byte;
               end
            end
            if (!len_bad && (pos0_ext == CmpW'(len_in) + CmpW'(DATA_POS))) begin
               pos_in  = '0;
               take_st = (req_data.rx_byte == chk_ff) ? ST_READY : ST_CHECK;
            end
         end
      end
   end

   always_comb begin
      res_timeout               = '0;
      res_timeout.status        = ST_TIMEOUT;
      res_timeout.byte_position = pos_ext[6:0];

      res_take               = '0;
      res_take.status        = take_st;
      res_take.byte_position = pos0_ext[6:0];
      res_take.last          = 1'b1;
      if (take_st == ST_READY) begin
         res_take.dest_addr = dest_ff;
         res_take.src_addr  = src_ff;
         res_take.command   = cmd_ff;
         res_take.arg_count = len_ff[5:0];
      end

      push_first  = restart ? res_timeout : res_take;
      push_second = res_take;
      if (!take) push_cnt = 2'd0;
      else       push_cnt = restart ? 2'd2 : 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         len_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dest_ff <= dest_in;
         src_ff  <= src_in;
         cmd_ff  <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= HEADER_RESET;
         chk_ff <= CHECK_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_HEADER: hdr_ff <= pwdata[7:0];
            REG_CHECK:  chk_ff <= pwdata[7:0];
            default:    hdr_ff <= hdr_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_HEADER: prdata = 32'(hdr_ff);
         REG_CHECK:  prdata = 32'(chk_ff);
         default:    prdata = '0;
      endcase
   end

   hlfr_result_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_first   (push_first),
      .push_second  (push_second),
      .push_cnt     (push_cnt),
      .room_for_two (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_fields_only_on_ready : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_READY) |->
         (rsp_data.dest_addr == 8'd0 && rsp_data.src_addr == 8'd0 &&
          rsp_data.command == 8'd0 && rsp_data.arg_count == 6'd0))
      else $error("frame fields set on a non-ready result");

   a_timeout_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_TIMEOUT) |-> !rsp_data.last)
      else $error("timeout result marked as last beat");

   a_timeout_two_beats : assert property (@(posedge clock) disable iff (reset)
      (take && req_data.timed_out && pos_ff != '0) |-> (push_cnt == 2'd2))
      else $error("mid-frame timeout did not queue two beats");
`endif

endmodule
